/* rtl/lda_pkg.sv */
// Shared constants, types and elaboration-time correction tables for the log-domain add/sub unit
package lda_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int TABLE_SEGMENTS = 256;   // power of two
   localparam int RANGE_LOG2     = 4;

   localparam int SEG_BITS = $clog2(TABLE_SEGMENTS);
   localparam int DIFF_W   = FRAC_BITS + RANGE_LOG2;   // corrections vanish at |a-b| >= 2^RANGE_LOG2
   localparam int POS_W    = $clog2(DIFF_W);
   localparam int WEIGHT_W = 16;
   localparam int TAB_W    = 34;
   localparam int DELTA_W  = 32;
   localparam int ACC_W    = 40;
   localparam int PROD_W   = DELTA_W + WEIGHT_W + 1;

   localparam bit FRAC_LT_30     = (FRAC_BITS < 30);
   localparam int RND_SHIFT      = FRAC_LT_30 ? 30 - FRAC_BITS : 0;
   localparam int RND_BIAS_SHIFT = FRAC_LT_30 ? 29 - FRAC_BITS : 0;
   localparam int UP_SHIFT       = FRAC_LT_30 ? 0 : FRAC_BITS - 30;
   localparam int CORR_W         = ACC_W + UP_SHIFT;
   localparam int SUM_W          = ((VALUE_WIDTH > CORR_W) ? VALUE_WIDTH : CORR_W) + 1;

   localparam longint       ONE_Q30   = longint'(1) << 30;
   localparam longint       LN2_Q30   = 744261118;
   localparam logic [63:0]  ONE_Q30_U = 64'(ONE_Q30);
   localparam logic [63:0]  LN2_Q30_U = 64'(LN2_Q30);

   localparam logic OP_LOG_ADD = 1'b0;
   localparam logic OP_LOG_SUB = 1'b1;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                          func;
      logic signed [VALUE_WIDTH-1:0] operand_a;
      logic signed [VALUE_WIDTH-1:0] operand_b;
   } lda_req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] result_value;
      logic                          is_neg_inf;
      logic                          saturated;
   } lda_rsp_type;

   typedef enum logic [1:0] {
      TAB_ADD,
      TAB_SUBG,
      TAB_LN
   } tab_sel_type;

   typedef logic signed [TAB_W-1:0]   base_tab_type  [TABLE_SEGMENTS];
   typedef logic signed [DELTA_W-1:0] delta_tab_type [TABLE_SEGMENTS];
   typedef logic signed [ACC_W-1:0]   pln_tab_type   [DIFF_W];

   function automatic int msb_pos(input logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = i;
      end
      return p;
   endfunction

   function automatic logic [63:0] udiv_q(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // signed quotient, truncated toward zero
   function automatic longint sdiv_q(input longint num, input longint den);
      logic [63:0] mag_n;
      logic [63:0] mag_d;
      logic [63:0] quo;
      mag_n = (num < 0) ? 64'(-num) : 64'(num);
      mag_d = (den < 0) ? 64'(-den) : 64'(den);
      quo   = udiv_q(mag_n, mag_d);
      if ((num < 0) != (den < 0)) return -longint'(quo);
      return longint'(quo);
   endfunction

   // e^-x, Q30 in and out
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
      logic [63:0] k;
      longint      r;
      longint      sum;
      longint      term;
      k    = udiv_q(x, LN2_Q30_U);
      r    = longint'(x - k * LN2_Q30_U);
      sum  = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 20; n++) begin
         term = -sdiv_q((term * r) >>> 30, longint'(n));
         sum  = sum + term;
      end
      if (k >= 62 || sum <= 0) return 64'd0;
      return 64'(sum) >> k;
   endfunction

   // ln(v), Q30 in and out
   function automatic longint ln_q30(input logic [63:0] v);
      int          p;
      logic [63:0] m;
      longint      z;
      longint      z2;
      longint      t;
      longint      s;
      if (v == 64'd0) return 0;
      p = msb_pos(v);
      s = 0;
      if (p >= 30) m = v >> (p - 30);
      else m = v << (30 - p);
      z  = longint'(udiv_q((m - ONE_Q30_U) << 30, m + ONE_Q30_U));
      z2 = (z * z) >>> 30;
      t  = z;
      for (int k = 0; k < 14; k++) begin
         s = s + sdiv_q(t, longint'(2 * k + 1));
         t = (t * z2) >>> 30;
      end
      return 2 * s + longint'(p - 30) * LN2_Q30;
   endfunction

   function automatic longint tab_value(input tab_sel_type sel, input int i);
      logic [63:0] ii;
      logic [63:0] x;
      longint      val;
      ii = 64'(i);
      x  = (ii << (30 + RANGE_LOG2)) >> SEG_BITS;
      case (sel)
         TAB_ADD: val = ln_q30(ONE_Q30_U + exp_neg_q30(x));
         TAB_SUBG: begin
            if (i == 0) val = 0;
            else val = ln_q30(ONE_Q30_U - exp_neg_q30(x)) - ln_q30(x);
         end
         TAB_LN: val = ln_q30(ONE_Q30_U + ((ii << 30) >> SEG_BITS));
         default: val = 0;
      endcase
      return val;
   endfunction

   function automatic base_tab_type tab_base(input tab_sel_type sel);
      base_tab_type t;
      for (int i = 0; i < TABLE_SEGMENTS; i++) begin
         t[i] = TAB_W'(tab_value(sel, i));
      end
      return t;
   endfunction

   function automatic delta_tab_type tab_delta(input tab_sel_type sel);
      delta_tab_type t;
      longint        prev;
      longint        cur;
      prev = tab_value(sel, 0);
      for (int i = 1; i <= TABLE_SEGMENTS; i++) begin
         cur      = tab_value(sel, i);
         t[i - 1] = DELTA_W'(cur - prev);
         prev     = cur;
      end
      return t;
   endfunction

   // exponent part of ln(d): (p - FRAC_BITS) * ln2 in Q30
   function automatic pln_tab_type tab_pln();
      pln_tab_type t;
      for (int p = 0; p < DIFF_W; p++) begin
         t[p] = ACC_W'(longint'(p - FRAC_BITS) * LN2_Q30);
      end
      return t;
   endfunction

   function automatic longint to_frac_const(input longint v);
      if (FRAC_LT_30) return (v + (longint'(1) << RND_BIAS_SHIFT)) >>> RND_SHIFT;
      return v <<< UP_SHIFT;
   endfunction

   localparam base_tab_type  ADD_BASE   = tab_base(TAB_ADD);
   localparam delta_tab_type ADD_DELTA  = tab_delta(TAB_ADD);
   localparam base_tab_type  SUBG_BASE  = tab_base(TAB_SUBG);
   localparam delta_tab_type SUBG_DELTA = tab_delta(TAB_SUBG);
   localparam base_tab_type  LN_BASE    = tab_base(TAB_LN);
   localparam delta_tab_type LN_DELTA   = tab_delta(TAB_LN);
   localparam pln_tab_type   PLN_TAB    = tab_pln();

   localparam logic signed [CORR_W-1:0] LN2_FRAC = CORR_W'(to_frac_const(LN2_Q30));
   localparam logic signed [CORR_W-1:0] RND_BIAS =
      FRAC_LT_30 ? CORR_W'(longint'(1) << RND_BIAS_SHIFT) : '0;

endpackage

/* rtl/lda_channels_if.sv */
// Request and response channel interfaces of the log-domain add/sub unit
interface lda_req_if import lda_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [VALUE_WIDTH-1:0] operand_a;
   logic signed [VALUE_WIDTH-1:0] operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

interface lda_rsp_if import lda_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] result_value;
   logic                          is_neg_inf;
   logic                          saturated;

   modport source (output valid, output result_value, output is_neg_inf, output saturated,
                   input ready);
   modport sink   (input valid, input result_value, input is_neg_inf, input saturated,
                   output ready);
endinterface

/* rtl/log_domain_add_sub_unit.sv */
// Top level of the log-domain add/sub unit: request register, datapath, response register
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------------------
//   req_chan  | in  | valid / ready | func, operand_a, operand_b (Q15.16)
//   rsp_chan  | out | valid / ready | result_value (Q15.16), is_neg_inf, saturated
//
// One request per cycle unless a response stalls; the response register loads when free.
// The path between the request register and the response register holds the
// table lookups and two interpolation multipliers, then the saturating add.
// Reset clears both valid flags; payload registers are not reset.
// While the response waits, one more request is taken and held in the request register.
module log_domain_add_sub_unit import lda_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lda_req_if.sink   req_chan,
   lda_rsp_if.source rsp_chan
);

   logic        in_valid_ff;
   logic        in_valid_in;
   lda_req_type in_data_ff;
   lda_req_type in_data_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   lda_rsp_type out_data_ff;
   lda_rsp_type out_data_in;
   logic        out_free;
   logic        advance;
   logic        take_req;
   lda_req_type req_data;
   lda_rsp_type calc_rsp;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;

   assign req_chan.ready = !in_valid_ff || out_free;
   assign take_req       = req_chan.valid && req_chan.ready;

   assign req_data.func      = req_chan.func;
   assign req_data.operand_a = req_chan.operand_a;
   assign req_data.operand_b = req_chan.operand_b;

   lda_calc u_calc (
      .req (in_data_ff),
      .rsp (calc_rsp)
   );

   always_comb begin
      in_valid_in  = take_req || (in_valid_ff && !out_free);
      in_data_in   = take_req ? req_data : in_data_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_data_in  = advance ? calc_rsp : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_data_ff.result_value;
   assign rsp_chan.is_neg_inf   = out_data_ff.is_neg_inf;
   assign rsp_chan.saturated    = out_data_ff.saturated;

endmodule

/* rtl/lda_corr.sv */
// Table-interpolated correction term ln(1+e^-d) or ln(1-e^-d), scaled to the value format
module lda_corr import lda_pkg::*; (
   input  logic                     func,
   input  logic [DIFF_W-1:0]        diff,
   output logic signed [CORR_W-1:0] corr
);

   logic [DIFF_W+WEIGHT_W-1:0] diff_pos;
   logic [SEG_BITS-1:0]        seg_idx;
   logic [WEIGHT_W-1:0]        seg_wt;
   logic [POS_W-1:0]           lead_pos;
   logic [DIFF_W-1:0]          diff_norm;
   logic [DIFF_W+WEIGHT_W-2:0] mant_ext;
   logic [WEIGHT_W-1:0]        mant;
   logic [SEG_BITS-1:0]        ln_idx;
   logic [WEIGHT_W-1:0]        ln_wt;
   logic signed [TAB_W-1:0]    seg_base;
   logic signed [DELTA_W-1:0]  seg_delta;
   logic signed [PROD_W-1:0]   seg_prod;
   logic signed [PROD_W-1:0]   ln_prod;
   logic signed [ACC_W-1:0]    seg_val;
   logic signed [ACC_W-1:0]    ln_val;
   logic signed [ACC_W-1:0]    sum_q30;
   logic signed [CORR_W-1:0]   sum_ext;

   // position of d within the segment tables
   assign diff_pos = {diff, WEIGHT_W'(0)};
   assign seg_idx  = diff[DIFF_W-1 -: SEG_BITS];
   assign seg_wt   = diff_pos[DIFF_W+WEIGHT_W-SEG_BITS-1 -: WEIGHT_W];

   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (diff[i]) lead_pos = POS_W'(i);
      end
   end

   // mantissa below the leading one, truncated to the weight width
   assign diff_norm = diff << (POS_W'(DIFF_W - 1) - lead_pos);
   assign mant_ext  = {diff_norm[DIFF_W-2:0], WEIGHT_W'(0)};
   assign mant      = mant_ext[DIFF_W+WEIGHT_W-2 -: WEIGHT_W];
   assign ln_idx    = mant[WEIGHT_W-1 -: SEG_BITS];
   assign ln_wt     = {mant[WEIGHT_W-SEG_BITS-1:0], SEG_BITS'(0)};

   always_comb begin
      if (func == OP_LOG_SUB) begin
         seg_base  = SUBG_BASE[seg_idx];
         seg_delta = SUBG_DELTA[seg_idx];
      end else begin
         seg_base  = ADD_BASE[seg_idx];
         seg_delta = ADD_DELTA[seg_idx];
      end
   end

   assign seg_prod = seg_delta * $signed({1'b0, seg_wt});
   assign ln_prod  = LN_DELTA[ln_idx] * $signed({1'b0, ln_wt});

   assign seg_val = ACC_W'(seg_base) + ACC_W'(seg_prod >>> WEIGHT_W);
   assign ln_val  = PLN_TAB[lead_pos] + ACC_W'(LN_BASE[ln_idx]) + ACC_W'(ln_prod >>> WEIGHT_W);

   always_comb begin
      if (func == OP_LOG_SUB) sum_q30 = ln_val + seg_val;
      else sum_q30 = seg_val;
   end

   assign sum_ext = CORR_W'(sum_q30);

   always_comb begin
      if (FRAC_LT_30) corr = (sum_ext + RND_BIAS) >>> RND_SHIFT;
      else corr = sum_ext <<< UP_SHIFT;
   end

endmodule

/* rtl/lda_calc.sv */
// Operand compare, correction select and saturating add for one request
module lda_calc import lda_pkg::*; (
   input  lda_req_type req,
   output lda_rsp_type rsp
);

   logic                          same;
   logic                          a_gt;
   logic signed [VALUE_WIDTH-1:0] hi;
   logic signed [VALUE_WIDTH-1:0] lo;
   logic [VALUE_WIDTH:0]          diff_full;
   logic [VALUE_WIDTH+DIFF_W:0]   diff_ext;
   logic                          in_range;
   logic signed [CORR_W-1:0]      tab_corr;
   logic signed [CORR_W-1:0]      corr;
   logic signed [SUM_W-1:0]       sum;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      {{(SUM_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   assign same = (req.operand_a == req.operand_b);
   assign a_gt = (req.operand_a > req.operand_b);
   assign hi   = a_gt ? req.operand_a : req.operand_b;
   assign lo   = a_gt ? req.operand_b : req.operand_a;

   assign diff_full = {hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo};
   assign diff_ext  = {DIFF_W'(0), diff_full};
   assign in_range  = (diff_ext[VALUE_WIDTH+DIFF_W:DIFF_W] == '0);

   lda_corr u_corr (
      .func (req.func),
      .diff (diff_ext[DIFF_W-1:0]),
      .corr (tab_corr)
   );

   always_comb begin
      if (req.func == OP_LOG_ADD && same) corr = LN2_FRAC;
      else if (in_range) corr = tab_corr;
      else corr = '0;
   end

   assign sum = SUM_W'(hi) + SUM_W'(corr);

   always_comb begin
      rsp.result_value = sum[VALUE_WIDTH-1:0];
      rsp.is_neg_inf   = 1'b0;
      rsp.saturated    = 1'b0;
      if (req.func == OP_LOG_SUB && !a_gt) begin
         rsp.result_value = VALUE_MIN;
         rsp.is_neg_inf   = 1'b1;
      end else if (sum > SUM_MAX) begin
         rsp.result_value = VALUE_MAX;
         rsp.saturated    = 1'b1;
      end else if (sum < SUM_MIN) begin
         rsp.result_value = VALUE_MIN;
         rsp.saturated    = 1'b1;
      end
   end

endmodule
